// ===== rtl/scanline_polygon_span_fill_unit_macros.svh =====
// assertion macros shared by the span fill unit
`ifndef SCANLINE_POLYGON_SPAN_FILL_UNIT_MACROS_SVH
`define SCANLINE_POLYGON_SPAN_FILL_UNIT_MACROS_SVH

// same-cycle implication under reset
`define SPF_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("span fill check failed");

// next-cycle implication under reset
`define SPF_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("span fill check failed");

`endif

// ===== rtl/spf_pkg.sv =====
// types, constants and state codes of the span fill unit
package spf_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 12;
    localparam int MAX_SPANS    = 8;
    localparam int IDX_BITS     = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int DCNT_BITS    = $clog2(PROD_BITS);
    localparam int SPAN_BITS    = $clog2(MAX_SPANS);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ROW  = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] vertex_x;
        logic [COORD_BITS-1:0] vertex_y;
        logic                  last_vertex;
    } req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] row_y;
        logic [COORD_BITS-1:0] span_start;
        logic [COORD_BITS-1:0] span_end;
        logic                  span_valid;
        logic                  last_span;
        logic                  polygon_done;
        logic                  overflow;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOPOLY,
        ST_RDA,
        ST_RDB,
        ST_EDGE,
        ST_DIV,
        ST_INS,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic start_row;
        logic sel_b;
        logic latch_a;
        logic edge_eval;
        logic div_step;
        logic insert;
        logic next_edge;
        logic emit_row;
        logic emit_none;
    } cmd_t;

    typedef struct packed {
        logic polygon_ready;
        logic crossing;
        logic div_last;
        logic edge_last;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/spf_ram.sv =====
// generic single-port-write ram with registered read
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/spf_ctrl.sv =====
// sequencer for vertex loading, edge walk, division and span output
module spf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_mode,
    output logic           req_stall,
    input  spf_pkg::stat_t stat,
    output spf_pkg::cmd_t  cmd
);

    spf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spf_pkg::ST_IDLE:
            begin
                if (req_valid && req_mode == spf_pkg::MODE_ROW)
                begin
                    state_next = stat.polygon_ready ? spf_pkg::ST_RDA : spf_pkg::ST_NOPOLY;
                end
            end
            spf_pkg::ST_NOPOLY:
            begin
                if (stat.out_free)
                begin
                    state_next = spf_pkg::ST_IDLE;
                end
            end
            spf_pkg::ST_RDA:  state_next = spf_pkg::ST_RDB;
            spf_pkg::ST_RDB:  state_next = spf_pkg::ST_EDGE;
            spf_pkg::ST_EDGE:
            begin
                priority if (stat.crossing)
                begin
                    state_next = spf_pkg::ST_DIV;
                end
                else if (stat.edge_last)
                begin
                    state_next = spf_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = spf_pkg::ST_RDA;
                end
            end
            spf_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = spf_pkg::ST_INS;
                end
            end
            spf_pkg::ST_INS:
            begin
                state_next = stat.edge_last ? spf_pkg::ST_EMIT : spf_pkg::ST_RDA;
            end
            spf_pkg::ST_EMIT:
            begin
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = spf_pkg::ST_IDLE;
                end
            end
            default: state_next = spf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            spf_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load      = (req_mode == spf_pkg::MODE_LOAD);
                    cmd.start_row = (req_mode == spf_pkg::MODE_ROW) && stat.polygon_ready;
                end
            end
            spf_pkg::ST_NOPOLY: cmd.emit_none = stat.out_free;
            spf_pkg::ST_RDA:    cmd.sel_b = 1'b0;
            spf_pkg::ST_RDB:
            begin
                cmd.sel_b   = 1'b1;
                cmd.latch_a = 1'b1;
            end
            spf_pkg::ST_EDGE:
            begin
                cmd.edge_eval = 1'b1;
                cmd.next_edge = !stat.crossing;
            end
            spf_pkg::ST_DIV:    cmd.div_step = 1'b1;
            spf_pkg::ST_INS:
            begin
                cmd.insert    = 1'b1;
                cmd.next_edge = 1'b1;
            end
            spf_pkg::ST_EMIT:   cmd.emit_row = stat.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule

// ===== rtl/spf_dp.sv =====
// vertex store, crossing arithmetic, sorted crossing row and result register
`include "scanline_polygon_span_fill_unit_macros.svh"

module spf_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  spf_pkg::req_t  req,
    input  spf_pkg::cmd_t  cmd,
    output spf_pkg::stat_t stat,
    output logic           res_valid,
    input  logic           res_stall,
    output spf_pkg::res_t  res
);

    localparam int CB = spf_pkg::COORD_BITS;
    localparam int IB = spf_pkg::IDX_BITS;
    localparam int NB = spf_pkg::CNT_BITS;
    localparam int PB = spf_pkg::PROD_BITS;
    localparam int NV = spf_pkg::MAX_VERTICES;

    logic [NB-1:0] count_reg, count_next;
    logic          ready_reg, ready_next;
    logic          ovf_reg, ovf_next;
    logic [CB-1:0] min_reg, min_next, max_reg, max_next, row_reg, row_next;
    logic [IB-1:0] edge_reg, edge_next;
    logic [CB-1:0] ax_reg, ay_reg;
    logic [CB-1:0] xi_reg;
    logic          neg_reg;
    logic [CB-1:0] den_reg, rem_reg;
    logic [PB-1:0] q_reg;
    logic [spf_pkg::DCNT_BITS-1:0] dcnt_reg;
    logic [CB-1:0] xbuf_reg [NV];
    logic [NB-1:0] cnt_reg;
    logic [spf_pkg::SPAN_BITS-1:0] spn_reg;
    logic          res_valid_reg;
    spf_pkg::res_t res_reg;

    logic [NB-1:0] eff_cnt;
    logic          store_ok;
    logic [IB-1:0] raddr, jdx;
    logic [2*CB-1:0] rdata;
    logic [CB-1:0] bx, by;
    logic          crossing;
    logic [CB-1:0] dy_mag, dx_mag, dr_mag;
    logic [CB:0]   rem_sh;
    logic          ge;
    logic [CB-1:0] xq, vcross;
    logic          gt [NV];
    logic          nospan, done, out_free;

    // effective fill level: a closed polygon is discarded by the next vertex
    assign eff_cnt  = ready_reg ? '0 : count_reg;
    assign store_ok = eff_cnt < NB'(NV);

    assign jdx   = ({1'b0, edge_reg} + 1'b1 == count_reg) ? '0 : edge_reg + 1'b1;
    assign raddr = cmd.sel_b ? jdx : edge_reg;

    spf_ram #(.WIDTH(2 * CB), .DEPTH(NV)) u_vstore (
        .clk   (clk),
        .we    (cmd.load && store_ok),
        .waddr (eff_cnt[IB-1:0]),
        .wdata ({req.vertex_x, req.vertex_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign bx = rdata[2*CB-1:CB];
    assign by = rdata[CB-1:0];

    assign crossing = (ay_reg <= row_reg && by > row_reg) || (by <= row_reg && ay_reg > row_reg);
    assign dy_mag   = (by > ay_reg) ? by - ay_reg : ay_reg - by;
    assign dx_mag   = (bx > ax_reg) ? bx - ax_reg : ax_reg - bx;
    assign dr_mag   = (row_reg > ay_reg) ? row_reg - ay_reg : ay_reg - row_reg;

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, q_reg[PB-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    assign xq     = q_reg[CB-1:0];
    assign vcross = neg_reg ? xi_reg - xq : xi_reg + xq;

    always_comb
    begin
        for (int p = 0; p < NV; p++)
        begin
            gt[p] = (NB'(p) < cnt_reg) && (xbuf_reg[p] > vcross);
        end
    end

    assign out_free = !res_valid_reg || !res_stall;
    assign nospan   = (cnt_reg < NB'(2)) && (spn_reg == '0);
    assign done     = row_reg == max_reg;

    assign stat.polygon_ready = ready_reg;
    assign stat.crossing      = crossing;
    assign stat.div_last      = dcnt_reg == spf_pkg::DCNT_BITS'(PB - 1);
    assign stat.edge_last     = {1'b0, edge_reg} + 1'b1 == count_reg;
    assign stat.emit_last     = nospan || (cnt_reg < NB'(4))
                                || (spn_reg == spf_pkg::SPAN_BITS'(spf_pkg::MAX_SPANS - 1));
    assign stat.out_free      = out_free;

    // polygon bookkeeping
    always_comb
    begin
        count_next = count_reg;
        ready_next = ready_reg;
        ovf_next   = ovf_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        row_next   = row_reg;
        if (cmd.load)
        begin
            ready_next = 1'b0;
            count_next = eff_cnt;
            if (store_ok)
            begin
                count_next = eff_cnt + 1'b1;
                if (eff_cnt == '0)
                begin
                    min_next = req.vertex_y;
                    max_next = req.vertex_y;
                end
                else
                begin
                    if (req.vertex_y < min_reg)
                    begin
                        min_next = req.vertex_y;
                    end
                    if (req.vertex_y > max_reg)
                    begin
                        max_next = req.vertex_y;
                    end
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (req.last_vertex)
            begin
                ready_next = 1'b1;
                row_next   = min_next;
            end
        end
        if (cmd.emit_row && stat.emit_last)
        begin
            if (done)
            begin
                ready_next = 1'b0;
                count_next = '0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            min_reg       <= '0;
            max_reg       <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ready_reg <= ready_next;
            ovf_reg   <= ovf_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            row_reg   <= row_next;
            if (cmd.emit_row || cmd.emit_none)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // edge walk, division, insertion and span output
    always_ff @(posedge clk)
    begin
        if (cmd.start_row)
        begin
            edge_reg <= '0;
            cnt_reg  <= '0;
            spn_reg  <= '0;
        end
        if (cmd.next_edge)
        begin
            edge_reg <= edge_reg + 1'b1;
        end
        if (cmd.latch_a)
        begin
            ax_reg <= bx;
            ay_reg <= by;
        end
        if (cmd.edge_eval && crossing)
        begin
            xi_reg   <= ax_reg;
            // on a crossing the row offset and dy share a sign, so x direction decides
            neg_reg  <= (bx < ax_reg);
            den_reg  <= dy_mag;
            rem_reg  <= '0;
            q_reg    <= dr_mag * dx_mag;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? CB'(rem_sh - {1'b0, den_reg}) : rem_sh[CB-1:0];
            q_reg    <= {q_reg[PB-2:0], ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.insert)
        begin
            for (int p = 0; p < NV; p++)
            begin
                if (NB'(p) <= cnt_reg)
                begin
                    if (p > 0 && gt[(p > 0) ? p - 1 : 0])
                    begin
                        xbuf_reg[p] <= xbuf_reg[(p > 0) ? p - 1 : 0];
                    end
                    else if (gt[p] || NB'(p) == cnt_reg)
                    begin
                        xbuf_reg[p] <= vcross;
                    end
                end
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.emit_row && !nospan)
        begin
            // drop the pair just sent
            for (int p = 0; p < NV - 2; p++)
            begin
                xbuf_reg[p] <= xbuf_reg[p + 2];
            end
            cnt_reg <= cnt_reg - NB'(2);
            spn_reg <= spn_reg + 1'b1;
        end
        if (cmd.emit_row)
        begin
            res_reg.row_y        <= row_reg;
            res_reg.span_start   <= nospan ? '0 : xbuf_reg[0];
            res_reg.span_end     <= nospan ? '0 : xbuf_reg[1];
            res_reg.span_valid   <= !nospan;
            res_reg.last_span    <= stat.emit_last;
            res_reg.polygon_done <= done;
            res_reg.overflow     <= ovf_reg;
        end
        if (cmd.emit_none)
        begin
            res_reg.row_y        <= row_reg;
            res_reg.span_start   <= '0;
            res_reg.span_end     <= '0;
            res_reg.span_valid   <= 1'b0;
            res_reg.last_span    <= 1'b1;
            res_reg.polygon_done <= 1'b1;
            res_reg.overflow     <= ovf_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `SPF_ASSERT_IMP(a_div_den_nonzero, clk, rst_n, cmd.div_step, den_reg != '0)
    `SPF_ASSERT_IMP(a_insert_room, clk, rst_n, cmd.insert, cnt_reg < NB'(NV))
    `SPF_ASSERT_IMP(a_ready_has_vertices, clk, rst_n, ready_reg, count_reg != '0)

endmodule

// ===== rtl/scanline_polygon_span_fill_unit.sv =====
// scanline polygon span fill: top level joining sequencer and datapath
//
// request channel req_valid/req_stall/req: mode 0 loads a vertex, mode 1
// sweeps the current row. last_vertex closes the polygon and sets the row
// to the lowest vertex row. up to 16 vertices are kept, further ones are
// dropped and the sticky overflow bit is raised.
// result channel res_valid/res_stall/res: one item per span, or one item
// without a span for an empty row; last_span marks the end of a row.
// a row reads both vertices of each edge from the store and tests the edge;
// each crossing then runs the restoring divider (one quotient bit a cycle)
// and is inserted in sorted order; the results then go out in turn, waiting
// while the result register is held. the divider and the single read port
// of the vertex store set the pace. a request is taken only between rows.
// the result register lets the next request be taken while the last result
// of a row still waits. while res_stall is high the held item stays and the
// sweep waits at the result register.
// reset clears the polygon, row, overflow and result valid; the vertex
// store holds no reset value and only written entries are ever read.
module scanline_polygon_span_fill_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spf_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_stall,
    output spf_pkg::res_t res
);

    spf_pkg::cmd_t  cmd;
    spf_pkg::stat_t stat;

    spf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
